### design/orbit_angles_to_position_assert.svh
// Assertion macros for the orbit position block.
`ifndef ORBIT_ANGLES_TO_POSITION_ASSERT_SVH
`define ORBIT_ANGLES_TO_POSITION_ASSERT_SVH
`ifndef SYNTH
`define OAP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OAP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OAP_ASSERT_IMP(lbl, ante, cons, msg)
`define OAP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### design/oap_pkg.sv
package oap_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

    localparam int XW = 34;
    localparam int ZW = 34;
    localparam int QW = 36;

    localparam logic signed [QW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [QW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [QW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [67:0]   ROUND_Q30   = 68'sd536870912;

    localparam longint PI_F     = (longint'(PI_Q30) + (longint'(1) << (ANG_SHIFT - 1)))
                                  >> ANG_SHIFT;
    localparam longint TWO_PI_F = (longint'(TWO_PI_Q30) + (longint'(1) << (ANG_SHIFT - 1)))
                                  >> ANG_SHIFT;

    localparam logic [1:0] REG_MIN_RADIUS  = 2'd0;
    localparam logic [1:0] REG_MAX_RADIUS  = 2'd1;
    localparam logic [1:0] REG_ELEV_MARGIN = 2'd2;

    localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
        34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
        34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
        34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
        34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
        34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
    };

    typedef struct packed {
        logic [30:0] min_radius;
        logic [30:0] max_radius;
        logic [16:0] elevation_margin;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [18:0]        az;
        logic [17:0]        el;
        logic [30:0]        r;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               neg_a;
        logic               neg_b;
    } pay_t;

endpackage

### design/oap_if.sv
interface oap_in_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] azimuth_in;
    logic signed [21:0] elevation_in;
    logic [30:0]        radius_in;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;

    modport source (output valid, azimuth_in, elevation_in, radius_in,
                    center_x, center_y, center_z, input ready);
    modport sink (input valid, azimuth_in, elevation_in, radius_in,
                  center_x, center_y, center_z, output ready);
endinterface

interface oap_out_if;
    logic               valid;
    logic               ready;
    logic [18:0]        azimuth_out;
    logic [17:0]        elevation_out;
    logic [30:0]        radius_out;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, azimuth_out, elevation_out, radius_out,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, azimuth_out, elevation_out, radius_out,
                  pos_x, pos_y, pos_z, output ready);
endinterface

### design/oap_prep.sv
module oap_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [21:0] az_in,
    input  logic signed [21:0] el_in,
    input  logic [30:0]        r_in,
    input  logic signed [31:0] cx_in,
    input  logic signed [31:0] cy_in,
    input  logic signed [31:0] cz_in,
    input  oap_pkg::cfg_t      cfg,
    input  logic               out_ready,
    output logic               out_valid,
    output oap_pkg::cordic_t   a_out,
    output oap_pkg::cordic_t   b_out,
    output oap_pkg::pay_t      pay_out
);
    import oap_pkg::*;

    typedef struct packed {
        logic signed [ZW-1:0] theta;
        logic                 neg;
    } fold_t;

    localparam logic signed [22:0] AZ_BIAS = 23'(6 * TWO_PI_F);
    localparam logic [22:0] T8 = 23'(8 * TWO_PI_F);
    localparam logic [22:0] T4 = 23'(4 * TWO_PI_F);
    localparam logic [22:0] T2 = 23'(2 * TWO_PI_F);
    localparam logic [22:0] T1 = 23'(TWO_PI_F);
    localparam logic signed [22:0] PI_S = 23'(PI_F);

    function automatic fold_t fold(input logic [18:0] ang);
        logic signed [QW-1:0] t;
        fold_t f;
        t = $signed(QW'(ang)) <<< ANG_SHIFT;
        f.neg = 1'b0;
        if (t > PI_Q30)
            t = t - TWO_PI_Q30;
        if (t > HALF_PI_Q30)
        begin
            t = PI_Q30 - t;
            f.neg = 1'b1;
        end
        else if (t < -HALF_PI_Q30)
        begin
            t = -PI_Q30 - t;
            f.neg = 1'b1;
        end
        f.theta = t[ZW-1:0];
        return f;
    endfunction

    logic  v0_reg, v1_reg;
    logic  adv0, adv1;
    pay_t  p0_reg, p0_next;
    pay_t  p1_reg, p1_next;
    cordic_t a_reg, a_next, b_reg, b_next;
    logic [22:0] w0, w1, w2, w3, w4;
    logic signed [22:0] el_lo, el_hi, el_v;
    logic [30:0] r_v;
    fold_t fa, fb;

    assign adv1     = !v1_reg || out_ready;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    // wrap azimuth: bias to positive, then peel off multiples of 2pi
    always_comb
    begin
        w0 = 23'($signed({az_in[21], az_in}) + AZ_BIAS);
        w1 = (w0 >= T8) ? w0 - T8 : w0;
        w2 = (w1 >= T4) ? w1 - T4 : w1;
        w3 = (w2 >= T2) ? w2 - T2 : w2;
        w4 = (w3 >= T1) ? w3 - T1 : w3;

        el_lo = $signed({6'b0, cfg.elevation_margin});
        el_hi = PI_S - el_lo;
        el_v  = $signed({el_in[21], el_in});
        if (el_v < el_lo)
            el_v = el_lo;
        if (el_v > el_hi)
            el_v = el_hi;

        r_v = r_in;
        if (r_v < cfg.min_radius)
            r_v = cfg.min_radius;
        if (r_v > cfg.max_radius)
            r_v = cfg.max_radius;

        p0_next       = '0;
        p0_next.az    = w4[18:0];
        p0_next.el    = el_v[17:0];
        p0_next.r     = r_v;
        p0_next.cx    = cx_in;
        p0_next.cy    = cy_in;
        p0_next.cz    = cz_in;
    end

    always_comb
    begin
        fa = fold(p0_reg.az);
        fb = fold({1'b0, p0_reg.el});
        p1_next       = p0_reg;
        p1_next.neg_a = fa.neg;
        p1_next.neg_b = fb.neg;
        a_next.x      = CORDIC_GAIN;
        a_next.y      = '0;
        a_next.z      = fa.theta;
        b_next.x      = CORDIC_GAIN;
        b_next.y      = '0;
        b_next.z      = fb.theta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                v0_reg <= in_valid;
            if (adv1)
                v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
            p0_reg <= p0_next;
        if (adv1)
        begin
            p1_reg <= p1_next;
            a_reg  <= a_next;
            b_reg  <= b_next;
        end
    end

    assign out_valid = v1_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign pay_out   = p1_reg;

endmodule

### design/oap_cordic_cell.sv
module oap_cordic_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [4:0]                     shift,
    input  logic signed [oap_pkg::ZW-1:0]  atan,
    input  oap_pkg::cordic_t               a_in,
    input  oap_pkg::cordic_t               b_in,
    input  oap_pkg::pay_t                  pay_in,
    input  logic                           out_ready,
    output logic                           out_valid,
    output oap_pkg::cordic_t               a_out,
    output oap_pkg::cordic_t               b_out,
    output oap_pkg::pay_t                  pay_out
);
    import oap_pkg::*;

    function automatic cordic_t rotate(input cordic_t c, input logic [4:0] s,
                                       input logic signed [ZW-1:0] at);
        cordic_t n;
        if (c.z >= 0)
        begin
            n.x = c.x - (c.y >>> s);
            n.y = c.y + (c.x >>> s);
            n.z = c.z - at;
        end
        else
        begin
            n.x = c.x + (c.y >>> s);
            n.y = c.y - (c.x >>> s);
            n.z = c.z + at;
        end
        return n;
    endfunction

    logic    valid_reg;
    cordic_t a_reg, b_reg;
    pay_t    pay_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            a_reg   <= rotate(a_in, shift, atan);
            b_reg   <= rotate(b_in, shift, atan);
            pay_reg <= pay_in;
        end
    end

    assign out_valid = valid_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign pay_out   = pay_reg;

endmodule

### design/orbit_angles_to_position.sv
// Orbit eye position from azimuth, elevation and radius around a center point.
// Pipeline from an accepted input word to the result word: 2 prep
// stages, 16 CORDIC cells, 2 multiply stages, 1 saturating output stage.
// Throughput: one word per cycle unless stalled; each stage advances on its own when free.
// Reset (rst_n low, asynchronous): all stages empty, registers at defaults.
`include "orbit_angles_to_position_assert.svh"

module orbit_angles_to_position (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    oap_in_if.sink      in_ch,
    oap_out_if.source   out_ch
);
    import oap_pkg::*;

    // configuration registers
    cfg_t cfg_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_radius       <= 31'd0;
            cfg_reg.max_radius       <= 31'd655360;
            cfg_reg.elevation_margin <= 17'd655;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MIN_RADIUS:  cfg_reg.min_radius       <= pwdata[30:0];
                REG_MAX_RADIUS:  cfg_reg.max_radius       <= pwdata[30:0];
                REG_ELEV_MARGIN: cfg_reg.elevation_margin <= pwdata[16:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_RADIUS:  prdata = {1'b0, cfg_reg.min_radius};
            REG_MAX_RADIUS:  prdata = {1'b0, cfg_reg.max_radius};
            REG_ELEV_MARGIN: prdata = {15'b0, cfg_reg.elevation_margin};
            default:         prdata = 32'd0;
        endcase
    end

    // front end: wrap, clamp, fold into the CORDIC range
    logic    c_valid [CORDIC_STAGES+1];
    logic    c_ready [CORDIC_STAGES+1];
    cordic_t c_a     [CORDIC_STAGES+1];
    cordic_t c_b     [CORDIC_STAGES+1];
    pay_t    c_pay   [CORDIC_STAGES+1];

    oap_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .az_in     (in_ch.azimuth_in),
        .el_in     (in_ch.elevation_in),
        .r_in      (in_ch.radius_in),
        .cx_in     (in_ch.center_x),
        .cy_in     (in_ch.center_y),
        .cz_in     (in_ch.center_z),
        .cfg       (cfg_reg),
        .out_ready (c_ready[0]),
        .out_valid (c_valid[0]),
        .a_out     (c_a[0]),
        .b_out     (c_b[0]),
        .pay_out   (c_pay[0])
    );

    // CORDIC row: one micro-rotation per cell, both angles side by side
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        oap_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .shift     (5'(i)),
            .atan      (ATAN_TAB[i]),
            .a_in      (c_a[i]),
            .b_in      (c_b[i]),
            .pay_in    (c_pay[i]),
            .out_ready (c_ready[i+1]),
            .out_valid (c_valid[i+1]),
            .a_out     (c_a[i+1]),
            .b_out     (c_b[i+1]),
            .pay_out   (c_pay[i+1])
        );
    end

    // multiply stage 1: sin(el) times cos/sin(az), rounded to Q30
    logic m1_valid_reg, m2_valid_reg, o_valid_reg;
    logic m1_adv, m2_adv, o_adv;
    logic signed [XW-1:0] ca, cb;
    logic signed [67:0]   p_sbca, p_sbsa;
    logic signed [QW-1:0] sbca_reg, sbsa_reg;
    logic signed [XW-1:0] cb_reg;
    pay_t                 m1_pay_reg, m2_pay_reg;

    assign o_adv  = !o_valid_reg || out_ch.ready;
    assign m2_adv = !m2_valid_reg || o_adv;
    assign m1_adv = !m1_valid_reg || m2_adv;
    assign c_ready[CORDIC_STAGES] = m1_adv;

    always_comb
    begin
        ca     = c_pay[CORDIC_STAGES].neg_a ? -c_a[CORDIC_STAGES].x : c_a[CORDIC_STAGES].x;
        cb     = c_pay[CORDIC_STAGES].neg_b ? -c_b[CORDIC_STAGES].x : c_b[CORDIC_STAGES].x;
        p_sbca = c_b[CORDIC_STAGES].y * ca;
        p_sbsa = c_b[CORDIC_STAGES].y * c_a[CORDIC_STAGES].y;
    end

    // multiply stage 2: radius times each direction component, rounded to Q16.16
    logic signed [31:0]   r_s;
    logic signed [67:0]   p_x, p_y, p_z;
    logic signed [37:0]   dx_reg, dy_reg, dz_reg;

    always_comb
    begin
        r_s = $signed({1'b0, m1_pay_reg.r});
        p_x = r_s * sbca_reg;
        p_y = r_s * cb_reg;
        p_z = r_s * sbsa_reg;
    end

    // output stage: add center, saturate to 32 bits
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                   input logic signed [37:0] d);
        logic signed [38:0] s;
        s = 39'(c) + 39'(d);
        if (s > 39'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -39'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m1_adv)
                m1_valid_reg <= c_valid[CORDIC_STAGES];
            if (m2_adv)
                m2_valid_reg <= m1_valid_reg;
            if (o_adv)
                o_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m1_adv)
        begin
            sbca_reg   <= QW'((p_sbca + ROUND_Q30) >>> 30);
            sbsa_reg   <= QW'((p_sbsa + ROUND_Q30) >>> 30);
            cb_reg     <= cb;
            m1_pay_reg <= c_pay[CORDIC_STAGES];
        end
        if (m2_adv)
        begin
            dx_reg     <= 38'((p_x + ROUND_Q30) >>> 30);
            dy_reg     <= 38'((p_y + ROUND_Q30) >>> 30);
            dz_reg     <= 38'((p_z + ROUND_Q30) >>> 30);
            m2_pay_reg <= m1_pay_reg;
        end
        if (o_adv)
        begin
            out_ch.azimuth_out   <= m2_pay_reg.az;
            out_ch.elevation_out <= m2_pay_reg.el;
            out_ch.radius_out    <= m2_pay_reg.r;
            out_ch.pos_x         <= sat_add(m2_pay_reg.cx, dx_reg);
            out_ch.pos_y         <= sat_add(m2_pay_reg.cy, dy_reg);
            out_ch.pos_z         <= sat_add(m2_pay_reg.cz, dz_reg);
        end
    end

    assign out_ch.valid = o_valid_reg;

    // stalls come only from the output side
    `OAP_ASSERT_IMP(a_stall_src, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
    `OAP_ASSERT_IMP(a_angle_rng, out_ch.valid, (out_ch.azimuth_out < 19'(TWO_PI_F)) && (out_ch.elevation_out <= 18'(PI_F)), "angle out of range")
    `OAP_ASSERT_IMP(a_radius_rng, out_ch.valid && (cfg_reg.min_radius <= cfg_reg.max_radius), (out_ch.radius_out >= cfg_reg.min_radius) && (out_ch.radius_out <= cfg_reg.max_radius), "radius outside limits")

endmodule

### tb/sv/testbench.sv
module testbench;

    import oap_pkg::*;

    // Fixed-point angle constants at 16 fraction bits, and the Q30 forms
    // that the sine/cosine rotation works in.
    localparam longint PI_FX       = 205887;
    localparam longint TWO_PI_FX   = 411775;
    localparam longint PI_Q        = 64'sd3373259426;
    localparam longint TWO_PI_Q    = 64'sd6746518852;
    localparam longint HALF_PI_Q   = 1686629713;
    localparam longint GAIN_Q      = 652032874;
    localparam longint HALF_LSB_Q  = 536870912;
    localparam int     ROT_STAGES  = 16;
    localparam int     SHIFT_Q     = 14;

    // Register map: register i sits at byte address 4*i.
    localparam logic [3:0] ADDR_MIN_RADIUS  = {REG_MIN_RADIUS, 2'b00};
    localparam logic [3:0] ADDR_MAX_RADIUS  = {REG_MAX_RADIUS, 2'b00};
    localparam logic [3:0] ADDR_ELEV_MARGIN = {REG_ELEV_MARGIN, 2'b00};
    localparam logic [3:0] ADDR_UNMAPPED    = 4'd12;

    localparam int DRAIN_CYCLES  = 40;
    localparam int RX_HOLD_LEN   = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEMS_PER_SET = 368;

    localparam longint ARCTAN_Q [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    typedef struct {
        logic signed [21:0] az;
        logic signed [21:0] el;
        logic [30:0]        r;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } angles_t;

    typedef struct {
        logic [18:0]        az;
        logic [17:0]        el;
        logic [30:0]        r;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } eye_t;

    // One directed row: the word to send and, where it is obvious, the
    // result typed in by hand.
    typedef struct {
        angles_t word;
        bit      typed;
        eye_t    result;
    } row_t;

    typedef struct {
        logic [31:0] min_r;
        logic [31:0] max_r;
        logic [31:0] margin;
    } reg_set_t;

    logic clk;
    logic rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    oap_in_if  in_ch ();
    oap_out_if out_ch ();

    orbit_angles_to_position u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Shadow copy of the block's registers, kept in step with each write.
    logic [30:0] shadow_min_r;
    logic [30:0] shadow_max_r;
    logic [16:0] shadow_margin;

    eye_t pending_eyes[$];
    int   error_count;
    int   cycle_count;
    bit   rx_hold_req;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Rotation-mode sine/cosine on a Q30 angle in [0, 2pi). Fold into the
    // right half plane first and flip the cosine back afterwards.
    function automatic void sin_cos_q30(input longint theta, output longint s,
                                        output longint c);
        longint x;
        longint y;
        longint z;
        longint t;
        bit     flip_cos;
        x = GAIN_Q;
        y = 0;
        flip_cos = 1'b0;
        if (theta > PI_Q)
            theta = theta - TWO_PI_Q;
        if (theta > HALF_PI_Q)
        begin
            theta = PI_Q - theta;
            flip_cos = 1'b1;
        end
        else if (theta < -HALF_PI_Q)
        begin
            theta = -PI_Q - theta;
            flip_cos = 1'b1;
        end
        z = theta;
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN_Q[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN_Q[i];
            end
            x = t;
        end
        s = y;
        c = flip_cos ? -x : x;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + HALF_LSB_Q) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp_add(input longint center,
                                                     input longint delta);
        longint v;
        v = center + delta;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Work out the eye point for one word under the current register values.
    function automatic eye_t place_eye(input angles_t w);
        eye_t   e;
        longint az;
        longint el;
        longint r;
        longint lo;
        longint hi;
        longint sa;
        longint ca;
        longint sb;
        longint cb;
        longint sb_ca;
        longint sb_sa;
        az = longint'(w.az) % TWO_PI_FX;
        if (az < 0)
            az = az + TWO_PI_FX;
        lo = longint'(shadow_margin);
        hi = PI_FX - lo;
        el = longint'(w.el);
        if (el < lo)
            el = lo;
        if (el > hi)
            el = hi;
        r = longint'(w.r);
        if (r < longint'(shadow_min_r))
            r = longint'(shadow_min_r);
        if (r > longint'(shadow_max_r))
            r = longint'(shadow_max_r);
        sin_cos_q30(az <<< SHIFT_Q, sa, ca);
        sin_cos_q30(el <<< SHIFT_Q, sb, cb);
        sb_ca = round_q30(sb * ca);
        sb_sa = round_q30(sb * sa);
        e.az = az[18:0];
        e.el = el[17:0];
        e.r  = r[30:0];
        e.px = clamp_add(longint'(w.cx), round_q30(r * sb_ca));
        e.py = clamp_add(longint'(w.cy), round_q30(r * cb));
        e.pz = clamp_add(longint'(w.cz), round_q30(r * sb_sa));
        return e;
    endfunction

    function automatic logic [31:0] pick_center();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
            3: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
            4, 5: return $urandom_range(0, 1 << 22) - (1 << 21);
            default: return $urandom;
        endcase
    endfunction

    // Random word: mostly angles around the useful range and radii near the
    // limits or up to 0xA00000, the rest anything the fields can hold.
    function automatic angles_t random_angles();
        angles_t w;
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 2) == 0)
            w.az = raw[21:0];
        else
            w.az = 22'($urandom_range(0, 900000)) - 22'sd450000;
        raw = $urandom;
        case ($urandom_range(0, 3))
            0: w.el = raw[21:0];
            1: w.el = 22'($urandom_range(0, 4000)) - 22'sd2000;
            2: w.el = 22'sd205887 - 22'($urandom_range(0, 4000)) + 22'sd2000;
            default: w.el = 22'($urandom_range(0, 205887));
        endcase
        raw = $urandom;
        case ($urandom_range(0, 4))
            0: w.r = raw[30:0];
            1: w.r = shadow_min_r + 31'($urandom_range(0, 100)) - 31'd50;
            2: w.r = shadow_max_r + 31'($urandom_range(0, 100)) - 31'd50;
            default: w.r = 31'($urandom_range(0, 32'h00A0_0000));
        endcase
        w.cx = pick_center();
        w.cy = pick_center();
        w.cz = pick_center();
        return w;
    endfunction

    // Offer one word and hold it until the block takes it; then record what
    // should come out.
    task automatic send_word(input angles_t w, input eye_t e);
        in_ch.valid        <= 1'b1;
        in_ch.azimuth_in   <= w.az;
        in_ch.elevation_in <= w.el;
        in_ch.radius_in    <= w.r;
        in_ch.center_x     <= w.cx;
        in_ch.center_y     <= w.cy;
        in_ch.center_z     <= w.cz;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        pending_eyes.push_back(e);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_eyes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access phase, then the bus goes idle before return, so that back-to-back
    // writes never drive the bus twice in one step.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_MIN_RADIUS:  shadow_min_r  = data[30:0];
            ADDR_MAX_RADIUS:  shadow_max_r  = data[30:0];
            ADDR_ELEV_MARGIN: shadow_margin = data[16:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Receiver: switch between always-ready, coin-flip, periodic and sparse
    // patterns, and honor a long hold-off when asked.
    initial
    begin
        int mode;
        int hold_left;
        mode = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (cycle_count % 5) != 0;
                    default: out_ch.ready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    // Compare every word leaving the block against the oldest expectation.
    always @(posedge clk)
    begin
        eye_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_eyes.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_eyes.pop_front();
                if (out_ch.azimuth_out !== e.az)
                begin
                    $error("azimuth_out expected %0d got %0d", e.az, out_ch.azimuth_out);
                    error_count++;
                end
                if (out_ch.elevation_out !== e.el)
                begin
                    $error("elevation_out expected %0d got %0d", e.el,
                           out_ch.elevation_out);
                    error_count++;
                end
                if (out_ch.radius_out !== e.r)
                begin
                    $error("radius_out expected %0d got %0d", e.r, out_ch.radius_out);
                    error_count++;
                end
                if (out_ch.pos_x !== e.px)
                begin
                    $error("pos_x expected %0d got %0d", e.px, out_ch.pos_x);
                    error_count++;
                end
                if (out_ch.pos_y !== e.py)
                begin
                    $error("pos_y expected %0d got %0d", e.py, out_ch.pos_y);
                    error_count++;
                end
                if (out_ch.pos_z !== e.pz)
                begin
                    $error("pos_z expected %0d got %0d", e.pz, out_ch.pos_z);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        row_t     rows [12];
        reg_set_t reg_sets [5];
        angles_t  w;
        int       burst_left;
        error_count  = 0;
        cycle_count  = 0;
        rx_hold_req  = 1'b0;
        shadow_min_r  = 31'd0;
        shadow_max_r  = 31'd655360;
        shadow_margin = 17'd655;

        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.azimuth_in   <= '0;
        in_ch.elevation_in <= '0;
        in_ch.radius_in    <= '0;
        in_ch.center_x     <= '0;
        in_ch.center_y     <= '0;
        in_ch.center_z     <= '0;

        // Rows with zero radius give the center back unchanged, so their
        // results can be written down directly.
        rows = '{
            '{'{22'sd0, 22'sd0, 31'd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
              '{19'd0, 18'd655, 31'd0, 32'sd0, 32'sd0, 32'sd0}},
            '{'{-22'sd2097152, -22'sd2097152, 31'd0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000}, 1'b1,
              '{19'd373498, 18'd655, 31'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}},
            '{'{-22'sd1, 22'sd2097151, 31'd0, 32'sd1, -32'sd1, 32'sd12345}, 1'b1,
              '{19'd411774, 18'd205232, 31'd0, 32'sd1, -32'sd1, 32'sd12345}},
            '{'{22'sd411775, 22'sd655, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF}, 1'b1,
              '{19'd0, 18'd655, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
            '{'{22'sd2097151, 22'sd2097151, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '{default: '0}},
            '{'{22'sd102944, 22'sd102944, 31'd655360, 32'sd0, 32'sd0, 32'sd0},
              1'b0, '{default: '0}},
            '{'{22'sd205887, 22'sd51472, 31'd655360, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000}, 1'b0, '{default: '0}},
            '{'{22'sd308831, 22'sd154416, 31'd327680, 32'h7FFF_0000, 32'h7FFF_0000,
                32'h7FFF_0000}, 1'b0, '{default: '0}},
            '{'{-22'sd102944, 22'sd1000, 31'd65536, -32'sd65536, 32'sd65536,
                32'sd0}, 1'b0, '{default: '0}},
            '{'{22'sd51472, 22'sd205000, 31'd1000000, 32'sd0, 32'sd0, 32'sd0},
              1'b0, '{default: '0}},
            '{'{22'sd12345, -22'sd5, 31'd1, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
              '{default: '0}},
            '{'{22'sd411774, 22'sd205232, 31'd655359, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000}, 1'b0, '{default: '0}}
        };

        // Register settings: full range with no margin; inverted limits with
        // a margin wider than a quarter turn; values with junk above the field
        // width; an ordinary mid setting; and the reset values again.
        reg_sets = '{
            '{32'd0, 32'h7FFF_FFFF, 32'd0},
            '{32'd2000000, 32'd100000, 32'd131071},
            '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFE_0000 | 32'd102943},
            '{32'd65536, 32'd6553600, 32'd1000},
            '{32'd0, 32'd655360, 32'd655}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset values of the registers.
        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed ? rows[i].result : place_eye(rows[i].word));
        drain();

        foreach (reg_sets[k])
        begin
            write_reg(ADDR_MIN_RADIUS, reg_sets[k].min_r);
            write_reg(ADDR_MAX_RADIUS, reg_sets[k].max_r);
            write_reg(ADDR_ELEV_MARGIN, reg_sets[k].margin);
            // An unmapped address must leave every register alone.
            if (k == 1)
                write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);

            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                // Starve the output for a while and keep pushing, so the
                // pipeline fills and backs up into the input.
                if (k == 0 && n == 40)
                    rx_hold_req = 1'b1;
                w = random_angles();
                send_word(w, place_eye(w));
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // Some stretches run back to back with no gaps at all.
                    if (k != 3 && $urandom_range(0, 2) != 0)
                    begin
                        in_ch.valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                end
                else
                    burst_left--;
            end
            // Hold the sender until every result of this setting is back.
            drain();
        end

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
